### src/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer package
// Shared types and constants for the console front end, queue and executor.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int MAX_ROWS   = 32;
	localparam int MAX_COLS   = 128;
	localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int PTR_W      = ADDR_W + 1;
	localparam int ROW_W      = 5;
	localparam int COL_W      = 8;
	localparam int RCFG_W     = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [7:0]  TEXT_ATTR       = 8'h07;
	localparam logic [7:0]  FIRST_PRINTABLE = 8'h20;
	localparam logic [7:0]  CH_LF           = 8'h0A;
	localparam logic [7:0]  CH_CR           = 8'h0D;
	localparam logic [7:0]  CH_TAB          = 8'h09;
	localparam logic [8:0]  TAB_MASK        = ~9'h007;

	// Input action codes
	localparam logic [1:0] ACT_PUT   = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

	localparam logic [RCFG_W-1:0] ROWS_RESET = 6'd25;
	localparam logic [COL_W-1:0]  COLS_RESET = 8'd80;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_CLEAR,
		OP_READ,
		OP_LF,
		OP_CR,
		OP_TAB,
		OP_PRINT,
		OP_IGNORE
	} op_kind_t;

	typedef struct packed {
		op_kind_t          kind;
		logic [7:0]        char_byte;
		logic [ADDR_W-1:0] read_index;
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} queue_head_t;

endpackage

### src/tcw_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console input channel
// Valid/ready channel carrying one console action.
// ----------------------------------------------------------------------------
interface tcw_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [7:0]  char_byte;
	logic [11:0] read_index;

	modport source (output valid, output action, output char_byte, output read_index,
		input ready);
	modport sink (input valid, input action, input char_byte, input read_index,
		output ready);
endinterface

### src/tcw_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console result channel
// Valid/ready channel carrying one result: read cell and cursor position.
// ----------------------------------------------------------------------------
interface tcw_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] cell_data;
	logic [4:0]  cursor_row;
	logic [7:0]  cursor_col;

	modport source (output valid, output cell_data, output cursor_row, output cursor_col,
		input ready);
	modport sink (input valid, input cell_data, input cursor_row, input cursor_col,
		output ready);
endinterface

### src/tcw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console operation queue
// Two-entry queue between the classifier and the executor.
// ----------------------------------------------------------------------------
module tcw_queue
	import tcw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  op_t         push_op,
	output logic        full,
	input  logic        pop,
	output queue_head_t head
);

	op_t        ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head.valid = (cnt_q != 2'd0);
	assign head.op    = ent_q[rd_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_op;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

### src/tcw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console front end
// Accepts input transfers, classifies each into an operation and queues it.
// ----------------------------------------------------------------------------
module tcw_front
	import tcw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	tcw_in_if.sink      in_ch,
	input  logic        busy,
	input  logic        pop,
	output queue_head_t head
);

	op_t  cls_op;
	logic full;
	logic push;

	assign in_ch.ready = !full && !busy;
	assign push        = in_ch.valid && in_ch.ready;

	// Classify the action and character
	always_comb begin
		cls_op.char_byte  = in_ch.char_byte;
		cls_op.read_index = in_ch.read_index;
		unique case (in_ch.action)
			ACT_PUT: begin
				priority if (in_ch.char_byte == CH_LF) cls_op.kind = OP_LF;
				else if (in_ch.char_byte == CH_CR) cls_op.kind = OP_CR;
				else if (in_ch.char_byte == CH_TAB) cls_op.kind = OP_TAB;
				else if (in_ch.char_byte >= FIRST_PRINTABLE) cls_op.kind = OP_PRINT;
				else cls_op.kind = OP_IGNORE;
			end
			ACT_CLEAR: cls_op.kind = OP_CLEAR;
			ACT_READ:  cls_op.kind = OP_READ;
			default:   cls_op.kind = OP_NOP;
		endcase
	end

	tcw_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (cls_op),
		.full    (full),
		.pop     (pop),
		.head    (head)
	);

endmodule

### src/tcw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console executor
// Owns the screen memory and cursor; runs writes, reads, scrolls and clears.
// ----------------------------------------------------------------------------
module tcw_back
	import tcw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  queue_head_t       head,
	output logic              pop,
	input  logic [RCFG_W-1:0] rows_eff,
	input  logic [COL_W-1:0]  cols_eff,
	output logic              busy,
	tcw_out_if.source         out_ch
);

	localparam logic [3:0] S_CLR      = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_DECIDE   = 4'd2;
	localparam logic [3:0] S_RDWAIT   = 4'd3;
	localparam logic [3:0] S_SC_SETUP = 4'd4;
	localparam logic [3:0] S_SC_RD    = 4'd5;
	localparam logic [3:0] S_SC_WR    = 4'd6;
	localparam logic [3:0] S_WRITE    = 4'd7;

	logic [15:0] mem [CELL_COUNT];
	logic [15:0] rd_data_q;

	logic [3:0]       state_q, state_d;
	op_t              op_q;
	logic [ROW_W-1:0] row_q, row_d;
	logic [COL_W-1:0] col_q, col_d;
	logic [PTR_W-1:0] ptr_q, ptr_d;
	logic [PTR_W-1:0] keep_q, end_q;
	logic             reply_q, reply_d;
	logic             wr_after_q, wr_after_d;

	logic              out_valid_q;
	logic [15:0]       out_cell_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [COL_W-1:0]  out_col_q;

	logic              fin;
	logic [15:0]       fin_cell;
	logic              out_free;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [15:0]       mem_wd;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_ra;

	logic [ROW_W-1:0] last_row;
	logic [ROW_W-1:0] row_clamp;
	logic [8:0]       tab_col;
	logic [PTR_W-1:0] cell_addr;
	logic [PTR_W-1:0] src_addr;

	assign out_free  = !out_valid_q || out_ch.ready;
	assign busy      = (state_q == S_CLR) && !reply_q;
	assign last_row  = ROW_W'(rows_eff - RCFG_W'(1));
	assign row_clamp = (row_q > last_row) ? last_row : row_q;
	assign tab_col   = (({1'b0, col_q} + 9'd8) & TAB_MASK);
	assign cell_addr = PTR_W'(row_q * cols_eff) + PTR_W'(col_q);
	assign src_addr  = ptr_q + PTR_W'(cols_eff);

	// Sequence operations
	always_comb begin
		state_d    = state_q;
		row_d      = row_q;
		col_d      = col_q;
		ptr_d      = ptr_q;
		reply_d    = reply_q;
		wr_after_d = wr_after_q;
		pop        = 1'b0;
		fin        = 1'b0;
		fin_cell   = 16'd0;
		mem_we     = 1'b0;
		mem_wa     = ptr_q[ADDR_W-1:0];
		mem_wd     = 16'd0;
		mem_re     = 1'b0;
		mem_ra     = head.op.read_index;
		unique case (state_q)
			S_CLR: begin
				mem_we = 1'b1;
				ptr_d  = ptr_q + PTR_W'(1);
				if (ptr_q == PTR_W'(CELL_COUNT - 1)) begin
					fin     = reply_q;
					reply_d = 1'b0;
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (head.valid && out_free) begin
					pop = 1'b1;
					unique case (head.op.kind)
						OP_NOP: fin = 1'b1;
						OP_READ: begin
							mem_re  = 1'b1;
							state_d = S_RDWAIT;
						end
						OP_CLEAR: begin
							row_d   = '0;
							col_d   = '0;
							ptr_d   = '0;
							reply_d = 1'b1;
							state_d = S_CLR;
						end
						default: state_d = S_DECIDE;
					endcase
				end
			end
			S_RDWAIT: begin
				fin      = 1'b1;
				fin_cell = rd_data_q;
				state_d  = S_IDLE;
			end
			S_DECIDE: begin
				row_d      = row_clamp;
				wr_after_d = 1'b0;
				state_d    = S_IDLE;
				unique case (op_q.kind)
					OP_LF: begin
						col_d = '0;
						if (row_clamp == last_row) begin
							state_d = S_SC_SETUP;
						end else begin
							row_d = row_clamp + ROW_W'(1);
							fin   = 1'b1;
						end
					end
					OP_CR: begin
						col_d = '0;
						fin   = 1'b1;
					end
					OP_TAB: begin
						col_d = (tab_col > {1'b0, cols_eff}) ? cols_eff : tab_col[COL_W-1:0];
						fin   = 1'b1;
					end
					OP_PRINT: begin
						wr_after_d = 1'b1;
						state_d    = S_WRITE;
						if (col_q >= cols_eff) begin
							col_d = '0;
							if (row_clamp == last_row) begin
								state_d = S_SC_SETUP;
							end else begin
								row_d = row_clamp + ROW_W'(1);
							end
						end
					end
					default: fin = 1'b1;
				endcase
			end
			S_SC_SETUP: begin
				ptr_d   = '0;
				state_d = S_SC_RD;
			end
			S_SC_RD: begin
				if (ptr_q >= end_q) begin
					if (wr_after_q) begin
						state_d = S_WRITE;
					end else begin
						fin     = 1'b1;
						state_d = S_IDLE;
					end
				end else if (ptr_q >= keep_q) begin
					mem_we = 1'b1;
					ptr_d  = ptr_q + PTR_W'(1);
				end else begin
					mem_re  = 1'b1;
					mem_ra  = src_addr[ADDR_W-1:0];
					state_d = S_SC_WR;
				end
			end
			S_SC_WR: begin
				mem_we  = 1'b1;
				mem_wd  = rd_data_q;
				ptr_d   = ptr_q + PTR_W'(1);
				state_d = S_SC_RD;
			end
			S_WRITE: begin
				mem_we  = (cell_addr < PTR_W'(CELL_COUNT));
				mem_wa  = cell_addr[ADDR_W-1:0];
				mem_wd  = {TEXT_ATTR, op_q.char_byte};
				col_d   = col_q + COL_W'(1);
				fin     = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Screen memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_ra];
		end
	end

	// Hold the current operation and scroll bounds
	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= head.op;
		end
		if (state_q == S_SC_SETUP) begin
			keep_q <= PTR_W'(last_row * cols_eff);
			end_q  <= PTR_W'(rows_eff * cols_eff);
		end
		if (fin) begin
			out_cell_q <= fin_cell;
			out_row_q  <= row_d;
			out_col_q  <= col_d;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			row_q       <= '0;
			col_q       <= '0;
			ptr_q       <= '0;
			reply_q     <= 1'b0;
			wr_after_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			row_q      <= row_d;
			col_q      <= col_d;
			ptr_q      <= ptr_d;
			reply_q    <= reply_d;
			wr_after_q <= wr_after_d;
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.cell_data  = out_cell_q;
	assign out_ch.cursor_row = out_row_q;
	assign out_ch.cursor_col = out_col_q;

endmodule

### src/text_console_writer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer
// Text screen of 16-bit cells with cursor, scroll, clear and cell read-back.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one action per transfer: put a byte, clear the screen or
//   read one cell. out_ch returns exactly one result per action: the read
//   cell (0 for other actions) and the cursor position after it.
//   cfg_we/cfg_index/cfg_data write rows_in_use (index 0) and cols_in_use
//   (index 1); write them only while the block is idle.
// Sequencing:
//   Printable byte: pop, decide, cell write, then the registered result.
//   Control byte: pop and decide; no-op: pop. Read: pop, then the
//   registered memory port. A scroll reads and rewrites each kept cell and
//   clears each cell of the last row in use; a clear sweeps all 4096 cells.
//   The registered read port of the screen memory sets these steps.
// Reset:
//   A clearing pass sweeps all 4096 cells, one per cycle; in_ch.ready stays
//   low until it ends. Registers return to 25 rows by 80 columns.
// Stalls:
//   The two-entry queue takes transfers while out_ch is stalled until full;
//   the executor holds its next operation until the result register is free.
// ----------------------------------------------------------------------------
module text_console_writer_top
	import tcw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	tcw_in_if.sink                in_ch,
	tcw_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [RCFG_W-1:0] rows_q;
	logic [COL_W-1:0]  cols_q;
	logic [RCFG_W-1:0] rows_eff;
	logic [COL_W-1:0]  cols_eff;
	queue_head_t       head;
	logic              pop;
	logic              busy;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RESET;
			cols_q <= COLS_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_ROWS) begin
				rows_q <= cfg_data[RCFG_W-1:0];
			end
			if (cfg_index == REG_COLS) begin
				cols_q <= cfg_data;
			end
		end
	end

	// Clamp geometry to the screen store
	always_comb begin
		priority if (rows_q == '0) rows_eff = RCFG_W'(1);
		else if (rows_q > RCFG_W'(MAX_ROWS)) rows_eff = RCFG_W'(MAX_ROWS);
		else rows_eff = rows_q;
		priority if (cols_q == '0) cols_eff = COL_W'(1);
		else if (cols_q > COL_W'(MAX_COLS)) cols_eff = COL_W'(MAX_COLS);
		else cols_eff = cols_q;
	end

	tcw_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.busy   (busy),
		.pop    (pop),
		.head   (head)
	);

	tcw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.rows_eff (rows_eff),
		.cols_eff (cols_eff),
		.busy     (busy),
		.out_ch   (out_ch)
	);

`ifndef SYNTHESIS
	a_no_accept_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy && in_ch.valid && in_ch.ready))
		else $error("input transfer taken during clearing pass");
	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("pop from empty queue");
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.cursor_col <= COL_W'(MAX_COLS)))
		else $error("cursor column beyond store");
`endif

endmodule
